### rtl/chc_pkg.sv
// Package for the compressor hysteresis controller.
// Widths, reset values, register indexes and shared structs; no dependencies.
`default_nettype none

package chc_pkg;

  localparam int TIME_WIDTH = 24;
  localparam int TEMP_WIDTH = 12;
  localparam int HYST_WIDTH = 8;
  // temperature sums and differences are formed exactly at this width
  localparam int CALC_WIDTH = TEMP_WIDTH + 2;
  localparam int CFG_IDX_WIDTH = 3;
  localparam int CFG_DATA_WIDTH = (TIME_WIDTH > TEMP_WIDTH) ? TIME_WIDTH : TEMP_WIDTH;

  localparam logic [TIME_WIDTH-1:0] TIME_MAX = {TIME_WIDTH{1'b1}};

  localparam logic signed [TEMP_WIDTH-1:0] SETPOINT_RST      = TEMP_WIDTH'(-288);
  localparam logic [HYST_WIDTH-1:0]        ON_HYST_RST       = HYST_WIDTH'(8);
  localparam logic [HYST_WIDTH-1:0]        OFF_HYST_RST      = HYST_WIDTH'(8);
  localparam logic [TIME_WIDTH-1:0]        MIN_ON_RST        = TIME_WIDTH'(60000);
  localparam logic [TIME_WIDTH-1:0]        MAX_ON_RST        = TIME_WIDTH'(3600000);
  localparam logic [TIME_WIDTH-1:0]        MIN_OFF_RST       = TIME_WIDTH'(180000);
  localparam logic signed [TEMP_WIDTH-1:0] EXPECTED_DROP_RST = TEMP_WIDTH'(16);

  typedef enum logic [CFG_IDX_WIDTH-1:0] {
    REG_SETPOINT      = 3'd0,
    REG_ON_HYST       = 3'd1,
    REG_OFF_HYST      = 3'd2,
    REG_MIN_ON        = 3'd3,
    REG_MAX_ON        = 3'd4,
    REG_MIN_OFF       = 3'd5,
    REG_EXPECTED_DROP = 3'd6
  } cfg_idx_t;

  typedef struct packed {
    logic signed [TEMP_WIDTH-1:0] setpoint;
    logic [HYST_WIDTH-1:0]        on_hysteresis;
    logic [HYST_WIDTH-1:0]        off_hysteresis;
    logic [TIME_WIDTH-1:0]        min_on_ticks;
    logic [TIME_WIDTH-1:0]        max_on_ticks;
    logic [TIME_WIDTH-1:0]        min_off_ticks;
    logic signed [TEMP_WIDTH-1:0] expected_drop;
  } cfg_t;

  typedef struct packed {
    logic compressor_on;
    logic alarm;
    logic alarm_checked;
  } result_t;

endpackage

`default_nettype wire

### rtl/chc_if.sv
// Handshake interfaces for the tick input, result output and register write channels.
// Depends on chc_pkg for field widths.
`default_nettype none

interface chc_in_if
  import chc_pkg::*;
();
  logic                         valid;
  logic                         ready;
  logic signed [TEMP_WIDTH-1:0] temperature;

  modport source (output valid, output temperature, input ready);
  modport sink   (input valid, input temperature, output ready);
endinterface

interface chc_out_if
  import chc_pkg::*;
();
  logic valid;
  logic ready;
  logic compressor_on;
  logic alarm;
  logic alarm_checked;

  modport source (output valid, output compressor_on, output alarm, output alarm_checked,
                  input ready);
  modport sink   (input valid, input compressor_on, input alarm, input alarm_checked,
                  output ready);
endinterface

interface chc_cfg_if
  import chc_pkg::*;
();
  logic                      valid;
  logic                      ready;
  logic [CFG_IDX_WIDTH-1:0]  index;
  logic [CFG_DATA_WIDTH-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### rtl/chc_cfg_regs.sv
// Configuration register bank of the compressor hysteresis controller.
// Depends on chc_pkg; index beyond the register list is ignored.
`default_nettype none

module chc_cfg_regs
  import chc_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      wr_en,
  input  wire logic [CFG_IDX_WIDTH-1:0]  wr_index,
  input  wire logic [CFG_DATA_WIDTH-1:0] wr_data,
  output cfg_t                           cfg
);

  cfg_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (cfg_idx_t'(wr_index))
        REG_SETPOINT:      cfg_nxt.setpoint       = wr_data[TEMP_WIDTH-1:0];
        REG_ON_HYST:       cfg_nxt.on_hysteresis  = wr_data[HYST_WIDTH-1:0];
        REG_OFF_HYST:      cfg_nxt.off_hysteresis = wr_data[HYST_WIDTH-1:0];
        REG_MIN_ON:        cfg_nxt.min_on_ticks   = wr_data[TIME_WIDTH-1:0];
        REG_MAX_ON:        cfg_nxt.max_on_ticks   = wr_data[TIME_WIDTH-1:0];
        REG_MIN_OFF:       cfg_nxt.min_off_ticks  = wr_data[TIME_WIDTH-1:0];
        REG_EXPECTED_DROP: cfg_nxt.expected_drop  = wr_data[TEMP_WIDTH-1:0];
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.setpoint       <= SETPOINT_RST;
      cfg_r.on_hysteresis  <= ON_HYST_RST;
      cfg_r.off_hysteresis <= OFF_HYST_RST;
      cfg_r.min_on_ticks   <= MIN_ON_RST;
      cfg_r.max_on_ticks   <= MAX_ON_RST;
      cfg_r.min_off_ticks  <= MIN_OFF_RST;
      cfg_r.expected_drop  <= EXPECTED_DROP_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

### rtl/chc_core.sv
// Per-tick decision logic and controller state (phase counter, run flag, alarm).
// Depends on chc_pkg; state advances only when a tick leaves the input register.
`default_nettype none

module chc_core
  import chc_pkg::*;
(
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         step,
  input  wire logic signed [TEMP_WIDTH-1:0] temperature,
  input  wire cfg_t                         cfg,
  output result_t                           result
);

  logic                         running_r, running_nxt;
  logic [TIME_WIDTH-1:0]        phase_r, phase_nxt;
  logic signed [TEMP_WIDTH-1:0] timeout_temp_r, timeout_temp_nxt;
  logic                         alarm_r, alarm_nxt;
  logic                         checked;

  logic [TIME_WIDTH-1:0]        elapsed;
  logic signed [CALC_WIDTH-1:0] temp_x, setpoint_x, drop_x, low_thr, high_thr, drop;

  always_comb begin
    // saturating increment: all ones means every minimum is over
    elapsed    = (phase_r == TIME_MAX) ? phase_r : phase_r + 1'b1;
    temp_x     = CALC_WIDTH'(temperature);
    setpoint_x = CALC_WIDTH'(cfg.setpoint);
    drop_x     = CALC_WIDTH'(cfg.expected_drop);
    low_thr    = setpoint_x - $signed({{(CALC_WIDTH-HYST_WIDTH){1'b0}}, cfg.off_hysteresis});
    high_thr   = setpoint_x + $signed({{(CALC_WIDTH-HYST_WIDTH){1'b0}}, cfg.on_hysteresis});
    drop       = CALC_WIDTH'(timeout_temp_r) - temp_x;

    running_nxt      = running_r;
    phase_nxt        = elapsed;
    timeout_temp_nxt = timeout_temp_r;
    alarm_nxt        = alarm_r;
    checked          = 1'b0;

    if (running_r) begin
      if (elapsed >= cfg.min_on_ticks) begin
        // temperature stop wins over the max-run timeout
        if (temp_x < low_thr) begin
          running_nxt = 1'b0;
          phase_nxt   = '0;
        end else if (elapsed > cfg.max_on_ticks) begin
          timeout_temp_nxt = temperature;
          alarm_nxt        = (drop < drop_x);
          checked          = 1'b1;
          running_nxt      = 1'b0;
          phase_nxt        = '0;
        end
      end
    end else begin
      if ((elapsed >= cfg.min_off_ticks) && (temp_x > high_thr)) begin
        running_nxt = 1'b1;
        phase_nxt   = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r      <= 1'b0;
      phase_r        <= TIME_MAX;
      timeout_temp_r <= '0;
      alarm_r        <= 1'b0;
    end else if (step) begin
      running_r      <= running_nxt;
      phase_r        <= phase_nxt;
      timeout_temp_r <= timeout_temp_nxt;
      alarm_r        <= alarm_nxt;
    end
  end

  assign result.compressor_on = running_nxt;
  assign result.alarm         = alarm_nxt;
  assign result.alarm_checked = checked;

endmodule

`default_nettype wire

### rtl/compressor_hysteresis_controller.sv
// Compressor hysteresis controller: thermostat with minimum on/off times and a
// max-run timeout that re-evaluates the cooling-ineffective alarm.
// Channels: in_ch carries one beat per millisecond tick with the measured
// temperature (signed, 1/16 degree). out_ch returns exactly one beat per tick
// with compressor_on, alarm and alarm_checked. cfg_ch writes register
// index/data (setpoint, hysteresis margins, run/rest times, expected drop);
// cfg_ch.ready is always high, writes are meant only while the block is idle
// and take effect on the next tick without restarting the current phase.
// An accepted tick passes the input register, then the result register, with
// the combinational decision logic between them. Throughput: one tick per
// cycle while the receiver keeps out_ch.ready high.
// Reset (rst_n low, synchronous): compressor off, phase counter saturated so
// the rest time has already expired, alarm cleared, registers at defaults.
// When the receiver stalls, the result register holds its beat and the input
// register still takes one more tick; in_ch.ready drops once both are full.
`default_nettype none

module compressor_hysteresis_controller
  import chc_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  chc_in_if.sink    in_ch,
  chc_out_if.source out_ch,
  chc_cfg_if.sink   cfg_ch
);

  cfg_t    cfg;
  result_t result;

  logic                         in_valid_r;
  logic signed [TEMP_WIDTH-1:0] in_temp_r;
  logic                         out_valid_r;
  result_t                      out_r;
  logic                         advance;
  logic                         in_ready;

  assign cfg_ch.ready = 1'b1;

  chc_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_ch.valid),
    .wr_index (cfg_ch.index),
    .wr_data  (cfg_ch.data),
    .cfg      (cfg)
  );

  // move the held tick into the result register when that slot is free
  assign advance  = in_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ready = !in_valid_r || advance;
  assign in_ch.ready = in_ready;

  chc_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (advance),
    .temperature (in_temp_r),
    .cfg         (cfg),
    .result      (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        in_valid_r <= in_ch.valid;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_ch.valid) begin
      in_temp_r <= in_ch.temperature;
    end
    if (advance) begin
      out_r <= result;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.compressor_on = out_r.compressor_on;
  assign out_ch.alarm         = out_r.alarm;
  assign out_ch.alarm_checked = out_r.alarm_checked;

endmodule

`default_nettype wire

### tb/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for compressor_hysteresis_controller: directed ticks, then random phases.
// Needs chc_pkg, the chc_*_if interfaces and the controller RTL; runs with no external input.

module tb;
  import chc_pkg::*;

  localparam logic [CFG_IDX_WIDTH-1:0] REG_SPARE = 3'd7;
  localparam int PHASES = 9;
  localparam int TICKS_PER_PHASE = 50;
  localparam int DRAIN_CYCLES = 4;
  localparam int LONG_STALL = 40;
  localparam int WATCHDOG_LIMIT = 2000;

  typedef struct {
    bit                          is_write;
    logic [CFG_IDX_WIDTH-1:0]    idx;
    logic [CFG_DATA_WIDTH-1:0]   data;
    logic signed [TEMP_WIDTH-1:0] temp;
    bit                          fixed;
    result_t                     want;
  } step_row_t;

  logic clk = 1'b0;
  logic rst_n;

  chc_in_if  in_ch ();
  chc_out_if out_ch ();
  chc_cfg_if cfg_ch ();

  compressor_hysteresis_controller dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // thermostat shadow: configuration
  logic signed [TEMP_WIDTH-1:0] set_temp;
  logic [HYST_WIDTH-1:0]        start_margin;
  logic [HYST_WIDTH-1:0]        stop_margin;
  logic [TIME_WIDTH-1:0]        min_run;
  logic [TIME_WIDTH-1:0]        max_run;
  logic [TIME_WIDTH-1:0]        min_rest;
  logic signed [TEMP_WIDTH-1:0] drop_limit;
  // thermostat shadow: state
  bit                           running;
  logic [TIME_WIDTH-1:0]        elapsed;
  logic signed [TEMP_WIDTH-1:0] timeout_temp;
  bit                           alarm_on;

  result_t   pending_outputs[$];
  step_row_t script[$];

  int errors = 0;
  int ticks_sent = 0;
  int writes_done = 0;
  int beats_checked = 0;
  int alarm_checks_seen = 0;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int stall_requests = 0;
  int idle_cycles = 0;
  bit cfg_open = 1'b0;

  function automatic void load_register(input logic [CFG_IDX_WIDTH-1:0] idx,
                                        input logic [CFG_DATA_WIDTH-1:0] d);
    case (idx)
      REG_SETPOINT:      set_temp = d[TEMP_WIDTH-1:0];
      REG_ON_HYST:       start_margin = d[HYST_WIDTH-1:0];
      REG_OFF_HYST:      stop_margin = d[HYST_WIDTH-1:0];
      REG_MIN_ON:        min_run = d[TIME_WIDTH-1:0];
      REG_MAX_ON:        max_run = d[TIME_WIDTH-1:0];
      REG_MIN_OFF:       min_rest = d[TIME_WIDTH-1:0];
      REG_EXPECTED_DROP: drop_limit = d[TEMP_WIDTH-1:0];
      default: ;
    endcase
  endfunction

  function automatic result_t thermostat_step(input logic signed [TEMP_WIDTH-1:0] t);
    result_t r;
    int      ti;
    int      drop;
    r = '0;
    ti = t;
    if (elapsed != TIME_MAX) elapsed++;
    if (running) begin
      if (elapsed >= min_run) begin
        // a temperature stop wins over the timeout and leaves the alarm alone
        if (ti < int'(set_temp) - int'(stop_margin)) begin
          running = 1'b0;
          elapsed = '0;
        end else if (elapsed > max_run) begin
          drop = int'(timeout_temp) - ti;
          timeout_temp = t;
          alarm_on = (drop < int'(drop_limit));
          r.alarm_checked = 1'b1;
          running = 1'b0;
          elapsed = '0;
        end
      end
    end else if (elapsed >= min_rest && ti > int'(set_temp) + int'(start_margin)) begin
      running = 1'b1;
      elapsed = '0;
    end
    r.compressor_on = running;
    r.alarm = alarm_on;
    return r;
  endfunction

  function automatic logic signed [TEMP_WIDTH-1:0] pick_temp();
    int sel;
    int v;
    sel = $urandom_range(0, 9);
    if (sel < 2) return TEMP_WIDTH'($urandom_range(0, (1 << TEMP_WIDTH) - 1));
    // hover around the start or the stop threshold
    v = (sel < 6) ? int'(set_temp) + int'(start_margin) : int'(set_temp) - int'(stop_margin);
    v += int'($urandom_range(0, 4)) - 2;
    if (v > 2047) v = 2047;
    if (v < -2048) v = -2048;
    return TEMP_WIDTH'(v);
  endfunction

  function automatic void add_write(input logic [CFG_IDX_WIDTH-1:0] idx,
                                    input logic [CFG_DATA_WIDTH-1:0] d);
    step_row_t s;
    s = '{default: '0};
    s.is_write = 1'b1;
    s.idx = idx;
    s.data = d;
    script.push_back(s);
  endfunction

  function automatic void add_tick(input logic signed [TEMP_WIDTH-1:0] t);
    step_row_t s;
    s = '{default: '0};
    s.temp = t;
    script.push_back(s);
  endfunction

  function automatic void add_fixed(input logic signed [TEMP_WIDTH-1:0] t,
                                    input bit on, input bit al, input bit chk);
    step_row_t s;
    s = '{default: '0};
    s.temp = t;
    s.fixed = 1'b1;
    s.want.compressor_on = on;
    s.want.alarm = al;
    s.want.alarm_checked = chk;
    script.push_back(s);
  endfunction

  // hold the input off until every beat has come back, then let the pipe settle
  task automatic quiesce();
    in_ch.valid <= 1'b0;
    while (pending_outputs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_WIDTH-1:0] idx,
                           input logic [CFG_DATA_WIDTH-1:0] d);
    if (!cfg_open) quiesce();
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= d;
    do @(posedge clk); while (!cfg_ch.ready);
    load_register(idx, d);
    cfg_open = 1'b1;
    writes_done++;
  endtask

  task automatic send_tick(input logic signed [TEMP_WIDTH-1:0] t, input bit fixed,
                           input result_t want);
    result_t r;
    if (cfg_open) begin
      cfg_ch.valid <= 1'b0;
      cfg_open = 1'b0;
    end
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.temperature <= t;
    do @(posedge clk); while (!in_ch.ready);
    r = thermostat_step(t);
    pending_outputs.push_back(fixed ? want : r);
    ticks_sent++;
  endtask

  initial begin : result_sink
    int stall_left;
    int stall_served;
    stall_left = 0;
    stall_served = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_requests != stall_served) begin
        stall_served = stall_requests;
        stall_left = LONG_STALL;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
    end
  end

  always @(posedge clk) begin : check_results
    result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_outputs.size() == 0) begin
        $error("result beat arrived with no tick outstanding");
        errors++;
      end else begin
        want = pending_outputs.pop_front();
        beats_checked++;
        if (out_ch.alarm_checked) alarm_checks_seen++;
        if (out_ch.compressor_on !== want.compressor_on) begin
          $error("compressor_on: expected %0b, got %0b", want.compressor_on,
                 out_ch.compressor_on);
          errors++;
        end
        if (out_ch.alarm !== want.alarm) begin
          $error("alarm: expected %0b, got %0b", want.alarm, out_ch.alarm);
          errors++;
        end
        if (out_ch.alarm_checked !== want.alarm_checked) begin
          $error("alarm_checked: expected %0b, got %0b", want.alarm_checked,
                 out_ch.alarm_checked);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    int p;
    int i;
    int sp;
    int hy;
    logic [CFG_DATA_WIDTH-1:0] d;
    logic [TIME_WIDTH-1:0] t_on;
    logic [TIME_WIDTH-1:0] t_max;
    logic [TIME_WIDTH-1:0] t_off;

    rst_n = 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.temperature <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= '0;
    cfg_ch.data <= '0;

    set_temp = SETPOINT_RST;
    start_margin = ON_HYST_RST;
    stop_margin = OFF_HYST_RST;
    min_run = MIN_ON_RST;
    max_run = MAX_ON_RST;
    min_rest = MIN_OFF_RST;
    drop_limit = EXPECTED_DROP_RST;
    running = 1'b0;
    elapsed = TIME_MAX;
    timeout_temp = '0;
    alarm_on = 1'b0;

    // saturated counter after reset clears even a rest time one below all ones
    add_write(REG_MIN_OFF, TIME_MAX - 1'b1);
    add_fixed(-2048, 1'b0, 1'b0, 1'b0);
    add_fixed(-280, 1'b0, 1'b0, 1'b0);
    add_fixed(-279, 1'b1, 1'b0, 1'b0);
    add_fixed(-2048, 1'b1, 1'b0, 1'b0);
    add_write(REG_MIN_ON, '0);
    add_fixed(-2048, 1'b0, 1'b0, 1'b0);
    add_write(REG_MIN_OFF, 2);
    add_tick(2047);
    add_tick(2047);
    add_write(REG_MAX_ON, 1);
    add_write(REG_EXPECTED_DROP, 24'h0007FF);
    add_tick(2047);
    add_fixed(2047, 1'b0, 1'b1, 1'b1);
    add_tick(2047);
    add_tick(2047);
    // most negative drop limit, carried with junk in the high data bits
    add_write(REG_EXPECTED_DROP, 24'hFFF800);
    add_tick(2047);
    add_fixed(-2048, 1'b0, 1'b1, 1'b0);
    add_write(REG_SPARE, 24'h000123);
    add_write(REG_SETPOINT, 24'hABC000);
    add_write(REG_ON_HYST, 24'hFFFF00);
    add_write(REG_OFF_HYST, 24'h1234FF);
    add_tick(1);
    add_tick(1);
    add_tick(-255);
    add_tick(-256);
    add_tick(2047);
    add_tick(2047);
    add_tick(2047);
    add_fixed(-255, 1'b0, 1'b0, 1'b1);

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    tx_idle_pct = 36;
    rx_idle_pct = 46;
    foreach (script[k]) begin
      if (script[k].is_write) write_reg(script[k].idx, script[k].data);
      else send_tick(script[k].temp, script[k].fixed, script[k].want);
    end

    for (p = 0; p < PHASES; p++) begin
      if (p == 3) begin
        tx_idle_pct = 46;
        rx_idle_pct = 36;
      end
      if (p == 6) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end

      case (p)
        2:       sp = -2048;
        3:       sp = 2047;
        default: sp = int'($urandom_range(0, 600)) - 300;
      endcase
      d = CFG_DATA_WIDTH'($urandom_range(0, (1 << CFG_DATA_WIDTH) - 1));
      d[TEMP_WIDTH-1:0] = TEMP_WIDTH'(sp);
      write_reg(REG_SETPOINT, d);

      hy = (p == 2) ? 0 : (p == 3) ? 255 : $urandom_range(0, 40);
      d = CFG_DATA_WIDTH'($urandom_range(0, (1 << CFG_DATA_WIDTH) - 1));
      d[HYST_WIDTH-1:0] = HYST_WIDTH'(hy);
      write_reg(REG_ON_HYST, d);
      hy = (p == 2) ? 0 : (p == 3) ? 255 : $urandom_range(0, 40);
      d = CFG_DATA_WIDTH'($urandom_range(0, (1 << CFG_DATA_WIDTH) - 1));
      d[HYST_WIDTH-1:0] = HYST_WIDTH'(hy);
      write_reg(REG_OFF_HYST, d);

      if (p == 0) begin
        t_on = '0;
        t_max = '0;
        t_off = '0;
      end else if (p == 1) begin
        // never-expiring run time: once started the compressor stays on
        t_on = TIME_MAX;
        t_max = TIME_MAX;
        t_off = 3;
      end else begin
        t_on = TIME_WIDTH'($urandom_range(0, 6));
        t_max = TIME_WIDTH'($urandom_range(0, 6));
        t_off = TIME_WIDTH'($urandom_range(0, 6));
      end
      write_reg(REG_MIN_ON, t_on);
      write_reg(REG_MAX_ON, t_max);
      write_reg(REG_MIN_OFF, t_off);
      write_reg(REG_EXPECTED_DROP,
                CFG_DATA_WIDTH'($urandom_range(0, (1 << CFG_DATA_WIDTH) - 1)));
      write_reg(REG_SPARE, CFG_DATA_WIDTH'($urandom_range(0, (1 << CFG_DATA_WIDTH) - 1)));

      for (i = 0; i < TICKS_PER_PHASE; i++) begin
        if (p == 1 && i == 20) stall_requests++;
        if (p == 4 && i == 25) quiesce();
        send_tick(pick_temp(), 1'b0, '0);
      end
    end

    quiesce();
    $display("%0d ticks and %0d register writes over %0d random settings", ticks_sent,
             writes_done, PHASES);
    $display("%0d result beats checked, %0d with an alarm re-evaluation", beats_checked,
             alarm_checks_seen);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
